### hdl/sos_pkg.sv
`default_nettype none

package sos_pkg;

	// run buffer
	localparam int RUN_DEPTH = 256;
	localparam int IDX_W     = $clog2(RUN_DEPTH);
	localparam int LEN_W     = $clog2(RUN_DEPTH + 1);

	// field widths
	localparam int ANG_W  = 9;
	localparam int DIST_W = 16;
	localparam int NUM_W  = 8;
	localparam int CTR_W  = 10;
	localparam int WID_W  = 10;

	// stream packing
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 48;

	// configuration registers
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OBJECT_LIMIT   = 1'd1;
	localparam logic [DIST_W-1:0]    THR_RESET = 16'd2400;
	localparam logic [NUM_W-1:0]     LIM_RESET = 8'd20;

	// controller -> datapath
	typedef struct packed {
		logic take;      // input transfer this cycle
		logic rd_step;   // issue one run buffer read
		logic load_out;  // load the result register
	} sos_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic report;    // item at the input ends a run that gets reported
		logic last;      // item at the input closes the scan
		logic rd_last;   // current read is the last of the run
		logic out_free;  // result register can take a new result
	} sos_stat_t;

endpackage

`default_nettype wire

### hdl/sos_ctrl.sv
`default_nettype none

module sos_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire sos_pkg::sos_stat_t st,
	output sos_pkg::sos_cmd_t       cmd
);
	import sos_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.take     = 1'b0;
		cmd.rd_step  = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (st.report)
						state_d = ST_READ;
					else if (st.last)
						state_d = ST_EMIT;
				end
			end
			ST_READ: begin
				cmd.rd_step = 1'b1;
				if (st.rd_last)
					state_d = ST_WAIT;
			end
			ST_WAIT: begin
				// last compare lands in this cycle
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

### hdl/sos_dp.sv
`default_nettype none

module sos_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sos_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sos_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [sos_pkg::ANG_W-1:0]       in_angle,
	input  wire logic [sos_pkg::DIST_W-1:0]      in_dist,
	input  wire logic                            in_last,
	input  wire sos_pkg::sos_cmd_t               cmd,
	output sos_pkg::sos_stat_t                   st,
	input  wire logic                            out_ready,
	output logic                                 out_valid,
	output logic                                 out_obj_valid,
	output logic [sos_pkg::NUM_W-1:0]            out_number,
	output logic [sos_pkg::CTR_W-1:0]            out_center,
	output logic [sos_pkg::DIST_W-1:0]           out_center_dist,
	output logic signed [sos_pkg::WID_W-1:0]     out_width,
	output logic                                 out_scan_end
);
	import sos_pkg::*;

	localparam int MEM_W = ANG_W + DIST_W;

	// configuration
	logic [DIST_W-1:0] thr_q;
	logic [NUM_W-1:0]  lim_q;

	// scan state
	logic [LEN_W-1:0] run_len_q;
	logic [NUM_W-1:0] obj_cnt_q;
	logic             limit_q;
	logic [ANG_W-1:0] start_ang_q;
	logic [ANG_W-1:0] end_ang_q;

	// pending result
	logic             rep_q;
	logic             last_q;
	logic [NUM_W-1:0] num_q;

	// walker
	logic [LEN_W-1:0]  walk_len_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [MEM_W-1:0]  rd_data_s1;
	logic              rd_vld_s1;
	logic              first_s1;
	logic [CTR_W-1:0]  min_err_q;
	logic [DIST_W-1:0] min_range_q;

	logic [MEM_W-1:0] mem [RUN_DEPTH];

	logic             near;
	logic             active;
	logic             ending;
	logic             report;
	logic             len_inc;
	logic [LEN_W-1:0] new_len;
	logic [IDX_W-1:0] slot;
	logic             wr_en;
	logic [CTR_W-1:0] centre;
	logic [CTR_W-1:0] twice;
	logic [CTR_W-1:0] diff;
	logic [ANG_W-1:0] rd_ang;
	logic [DIST_W-1:0] rd_dist;

	assign near    = in_dist < thr_q;
	assign active  = (run_len_q != '0) || near;
	assign ending  = !limit_q && active && (!near || in_last);
	assign report  = ending && (obj_cnt_q < lim_q);
	assign len_inc = near && (run_len_q < LEN_W'(RUN_DEPTH));
	assign new_len = run_len_q + LEN_W'(len_inc);
	assign slot    = len_inc ? run_len_q[IDX_W-1:0] : IDX_W'(RUN_DEPTH - 1);
	assign wr_en   = cmd.take && !limit_q && near;

	assign st.report   = report;
	assign st.last     = in_last;
	assign st.rd_last  = ({1'b0, rd_idx_q} == LEN_W'(walk_len_q - LEN_W'(1)));
	assign st.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			lim_q <= LIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEAR_THRESHOLD: thr_q <= cfg_data;
				REG_OBJECT_LIMIT:   lim_q <= cfg_data[NUM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q <= '0;
			obj_cnt_q <= '0;
			limit_q   <= 1'b0;
		end else if (cmd.take) begin
			if (ending) begin
				run_len_q <= '0;
				if (report)
					obj_cnt_q <= obj_cnt_q + NUM_W'(1);
				else
					limit_q <= 1'b1;
			end else if (!limit_q) begin
				run_len_q <= new_len;
			end
			if (in_last) begin
				run_len_q <= '0;
				obj_cnt_q <= '0;
				limit_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			end_ang_q <= in_angle;
			if (run_len_q == '0)
				start_ang_q <= in_angle;
		end
		if (cmd.take) begin
			rep_q  <= report;
			last_q <= in_last;
			num_q  <= obj_cnt_q + NUM_W'(1);
			if (ending)
				walk_len_q <= new_len;
		end
	end

	// run buffer
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[slot] <= {in_dist, in_angle};
		if (cmd.rd_step)
			rd_data_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_step;
			if (cmd.take)
				rd_idx_q <= '0;
			else if (cmd.rd_step)
				rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
	end

	// nearest-to-centre search, earliest wins on ties
	assign centre  = {1'b0, start_ang_q} + {1'b0, end_ang_q};
	assign rd_ang  = rd_data_s1[ANG_W-1:0];
	assign rd_dist = rd_data_s1[MEM_W-1:ANG_W];
	assign twice   = {rd_ang, 1'b0};
	assign diff    = (twice >= centre) ? twice - centre : centre - twice;

	always_ff @(posedge clk) begin
		if (cmd.rd_step)
			first_s1 <= (rd_idx_q == '0);
		if (rd_vld_s1 && (first_s1 || diff < min_err_q)) begin
			min_err_q   <= diff;
			min_range_q <= rd_dist;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.load_out)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_obj_valid <= rep_q;
			out_scan_end  <= last_q;
			if (rep_q) begin
				out_number      <= num_q;
				out_center      <= centre;
				out_center_dist <= min_range_q;
				out_width       <= WID_W'({1'b0, end_ang_q} - {1'b0, start_ang_q});
			end else begin
				out_number      <= '0;
				out_center      <= '0;
				out_center_dist <= '0;
				out_width       <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_len_q <= LEN_W'(RUN_DEPTH))
		else $error("run length beyond buffer depth");

	a_limit_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q |-> (run_len_q == '0))
		else $error("run kept after object limit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	a_rd_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_step |-> ({1'b0, rd_idx_q} < walk_len_q))
		else $error("read past end of run");
`endif

endmodule

`default_nettype wire

### hdl/scan_object_segmentation_top.sv
`default_nettype none

// Scan object segmentation. Readings (angle, distance) arrive one per transfer;
// a reading is near when its distance is below near_threshold. A run of near
// readings is stored in a run buffer of RUN_DEPTH entries. When a far reading
// or the scan's last reading closes a run, the buffer is walked once to find
// the reading nearest the run centre, and one object result is sent. The
// last reading of a scan always produces a result (an object, or an empty end
// marker with tuser low) with tlast set, and clears the scan state. After
// object_limit objects further runs are dropped until the scan ends. A reading
// with no result is only accepted; a last reading with only the end marker is
// accepted, then its result loaded; one reporting a run of L kept readings is
// accepted, its L entries are read on the single read port, the last read is
// compared and the result loaded, and only then is a new reading taken.
// A finished result waits in the output register while the next reading is
// taken; a new result is held back only until it leaves. The user must see
// that configuration is written via cfg_we/cfg_index/cfg_data only while idle.
module scan_object_segmentation_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [sos_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sos_pkg::CFG_DATA_W-1:0]  cfg_data,
	// reading input
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [sos_pkg::S_DATA_W-1:0]    s_tdata,  // angle_deg[8:0], distance_mm[24:9]
	input  wire logic                            s_tlast,  // scan_last
	// object output
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [sos_pkg::M_DATA_W-1:0]         m_tdata,  // object_number[7:0],
	                                                       // center_half_deg[17:8],
	                                                       // center_distance_mm[33:18],
	                                                       // object_width[43:34]
	output logic                                 m_tuser,  // object_valid
	output logic                                 m_tlast   // scan_end
);
	import sos_pkg::*;

	sos_cmd_t  cmd;
	sos_stat_t st;

	logic [NUM_W-1:0]        number;
	logic [CTR_W-1:0]        center;
	logic [DIST_W-1:0]       center_dist;
	logic signed [WID_W-1:0] width;

	// sequencing: accept, buffer walk, result load
	sos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// scan state, run buffer, centre search and result register
	sos_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_angle        (s_tdata[ANG_W-1:0]),
		.in_dist         (s_tdata[ANG_W+DIST_W-1:ANG_W]),
		.in_last         (s_tlast),
		.cmd             (cmd),
		.st              (st),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_obj_valid   (m_tuser),
		.out_number      (number),
		.out_center      (center),
		.out_center_dist (center_dist),
		.out_width       (width),
		.out_scan_end    (m_tlast)
	);

	// pack result fields, low bits first, zero pad to whole bytes
	assign m_tdata = {
		{(M_DATA_W - NUM_W - CTR_W - DIST_W - WID_W){1'b0}},
		width, center_dist, center, number
	};

endmodule

`default_nettype wire
